FILE: rtl/cbspl_pkg.sv
// Shared constants and saturation helpers for the cubic B-spline evaluator.
// No dependencies; used by cubic_bspline_point_and_tangent_core.
package cbspl_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int T_FRAC_BITS = 16;

   localparam int TAN_WIDTH   = COORD_WIDTH + 2;
   localparam int POINT_WIDTH = 3 * COORD_WIDTH;
   localparam int T_WIDTH     = T_FRAC_BITS + 1;
   localparam int SQ_WIDTH    = 2 * T_WIDTH;
   // six-fold weights stay within +/- 12 * one
   localparam int WGT_WIDTH   = T_FRAC_BITS + 5;
   localparam int PROD_WIDTH  = WGT_WIDTH + COORD_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   // sum >>> (F+1): the power-of-two part of the divide by 6 * 2^F
   localparam int MQ_WIDTH    = SUM_WIDTH - T_FRAC_BITS - 1;
   localparam int MU_WIDTH    = MQ_WIDTH + 1;
   localparam int QUO_WIDTH   = MQ_WIDTH;
   // divide by 3 through a reciprocal multiply
   localparam int DIV_SHIFT   = MU_WIDTH + 2;
   localparam int RECIP_WIDTH = DIV_SHIFT - 1;
   localparam int DPROD_WIDTH = MU_WIDTH + RECIP_WIDTH;
   localparam int N_STAGES    = 7;
   localparam int N_AXES      = 3;
   localparam int N_PTS       = 4;
   localparam int N_RES       = 2 * N_AXES;

   localparam logic [RECIP_WIDTH-1:0] DIV_RECIP =
      RECIP_WIDTH'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);

   localparam logic [T_WIDTH-1:0]   ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
   localparam logic [SQ_WIDTH-1:0]  HALF = SQ_WIDTH'(1) << (T_FRAC_BITS - 1);
   localparam logic [SUM_WIDTH-1:0] ROUND_OFS = SUM_WIDTH'(3) << T_FRAC_BITS;
   localparam logic [MU_WIDTH-1:0]  MU_BIAS = MU_WIDTH'(3) << (MQ_WIDTH - 1);
   localparam logic [QUO_WIDTH-1:0] Q_BIAS  = QUO_WIDTH'(1) << (MQ_WIDTH - 1);

   localparam logic signed [QUO_WIDTH-1:0] POS_MAX =
      QUO_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [QUO_WIDTH-1:0] POS_MIN =
      QUO_WIDTH'(-(64'sd1 <<< (COORD_WIDTH - 1)));
   localparam logic signed [QUO_WIDTH-1:0] TAN_MAX =
      QUO_WIDTH'((64'sd1 <<< (TAN_WIDTH - 1)) - 64'sd1);
   localparam logic signed [QUO_WIDTH-1:0] TAN_MIN =
      QUO_WIDTH'(-(64'sd1 <<< (TAN_WIDTH - 1)));

   function automatic logic signed [COORD_WIDTH-1:0] sat_pos(
      input logic signed [QUO_WIDTH-1:0] v);
      logic signed [QUO_WIDTH-1:0] c;
      c = v;
      if (v > POS_MAX) c = POS_MAX;
      if (v < POS_MIN) c = POS_MIN;
      return c[COORD_WIDTH-1:0];
   endfunction

   function automatic logic signed [TAN_WIDTH-1:0] sat_tan(
      input logic signed [QUO_WIDTH-1:0] v);
      logic signed [QUO_WIDTH-1:0] c;
      c = v;
      if (v > TAN_MAX) c = TAN_MAX;
      if (v < TAN_MIN) c = TAN_MIN;
      return c[TAN_WIDTH-1:0];
   endfunction

endpackage

FILE: rtl/cubic_bspline_point_and_tangent_core.sv
// Uniform cubic B-spline evaluator, point and tangent per request; uses cbspl_pkg.
// One request per cycle unless req_stall is high; the 7 register stages (t^2, t^3,
// weights, products, sums, divide by 3, saturate) lie between request and result.
// Stages with no request fill in while the result side stalls.
// Reset (synchronous, active high) clears the stage valid bits only.
module cubic_bspline_point_and_tangent_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [cbspl_pkg::POINT_WIDTH-1:0] req_point_a,
   input  logic [cbspl_pkg::POINT_WIDTH-1:0] req_point_b,
   input  logic [cbspl_pkg::POINT_WIDTH-1:0] req_point_c,
   input  logic [cbspl_pkg::POINT_WIDTH-1:0] req_point_d,
   input  logic [cbspl_pkg::T_WIDTH-1:0] req_param_t,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [cbspl_pkg::COORD_WIDTH-1:0] rsp_pos_x,
   output logic signed [cbspl_pkg::COORD_WIDTH-1:0] rsp_pos_y,
   output logic signed [cbspl_pkg::COORD_WIDTH-1:0] rsp_pos_z,
   output logic signed [cbspl_pkg::TAN_WIDTH-1:0] rsp_tan_x,
   output logic signed [cbspl_pkg::TAN_WIDTH-1:0] rsp_tan_y,
   output logic signed [cbspl_pkg::TAN_WIDTH-1:0] rsp_tan_z
);

   localparam int NS = cbspl_pkg::N_STAGES;
   localparam int C  = cbspl_pkg::COORD_WIDTH;
   localparam int F  = cbspl_pkg::T_FRAC_BITS;
   localparam int NA = cbspl_pkg::N_AXES;
   localparam int NP = cbspl_pkg::N_PTS;
   localparam int NR = cbspl_pkg::N_RES;

   // ---------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or when
   // the stage after it moves, so bubbles collapse under a stall.
   // ---------------------------------------------------------------
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 0: clamp t to 1.0, square it.
   // ---------------------------------------------------------------
   logic [cbspl_pkg::T_WIDTH-1:0]     t_in;
   logic [cbspl_pkg::T_WIDTH-1:0]     s0_t_ff;
   logic [cbspl_pkg::SQ_WIDTH-1:0]    s0_sq_in, s0_sq_ff;
   logic [cbspl_pkg::POINT_WIDTH-1:0] s0_pt_in [NP];
   logic [cbspl_pkg::POINT_WIDTH-1:0] s0_pt_ff [NP];

   always_comb begin
      t_in = (req_param_t > cbspl_pkg::ONE) ? cbspl_pkg::ONE : req_param_t;
      s0_sq_in = t_in * t_in;
      s0_pt_in[0] = req_point_a;
      s0_pt_in[1] = req_point_b;
      s0_pt_in[2] = req_point_c;
      s0_pt_in[3] = req_point_d;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_t_ff  <= t_in;
         s0_sq_ff <= s0_sq_in;
         s0_pt_ff <= s0_pt_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: round t^2, form t^2 * t.
   // ---------------------------------------------------------------
   logic [cbspl_pkg::SQ_WIDTH-1:0]    s1_sq_rnd;
   logic [cbspl_pkg::T_WIDTH-1:0]     s1_t2_in, s1_t2_ff, s1_t_ff;
   logic [cbspl_pkg::SQ_WIDTH-1:0]    s1_cu_in, s1_cu_ff;
   logic [cbspl_pkg::POINT_WIDTH-1:0] s1_pt_ff [NP];

   always_comb begin
      s1_sq_rnd = (s0_sq_ff + cbspl_pkg::HALF) >> F;
      s1_t2_in  = s1_sq_rnd[cbspl_pkg::T_WIDTH-1:0];
      s1_cu_in  = s1_t2_in * s0_t_ff;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_t_ff  <= s0_t_ff;
         s1_t2_ff <= s1_t2_in;
         s1_cu_ff <= s1_cu_in;
         s1_pt_ff <= s0_pt_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: round t^3, build six-fold point and tangent weights.
   // ---------------------------------------------------------------
   localparam int W = cbspl_pkg::WGT_WIDTH;
   logic [cbspl_pkg::SQ_WIDTH-1:0]    s2_cu_rnd;
   logic signed [W-1:0]               ts, t2s, t3s, ones;
   logic signed [W-1:0]               s2_w_in [NP];
   logic signed [W-1:0]               s2_d_in [NP];
   logic signed [W-1:0]               s2_w_ff [NP];
   logic signed [W-1:0]               s2_d_ff [NP];
   logic [cbspl_pkg::POINT_WIDTH-1:0] s2_pt_ff [NP];

   always_comb begin
      s2_cu_rnd = (s1_cu_ff + cbspl_pkg::HALF) >> F;
      ts   = W'(s1_t_ff);
      t2s  = W'(s1_t2_ff);
      t3s  = W'(s2_cu_rnd[cbspl_pkg::T_WIDTH-1:0]);
      ones = W'(cbspl_pkg::ONE);
      s2_w_in[0] = W'(ones - t3s + 3 * t2s - 3 * ts);
      s2_w_in[1] = W'(3 * t3s - 6 * t2s + 4 * ones);
      s2_w_in[2] = W'(ones - 3 * t3s + 3 * t2s + 3 * ts);
      s2_w_in[3] = t3s;
      s2_d_in[0] = W'(6 * ts - 3 * t2s - 3 * ones);
      s2_d_in[1] = W'(9 * t2s - 12 * ts);
      s2_d_in[2] = W'(6 * ts - 9 * t2s + 3 * ones);
      s2_d_in[3] = W'(3 * t2s);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_w_ff  <= s2_w_in;
         s2_d_ff  <= s2_d_in;
         s2_pt_ff <= s1_pt_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: weight times coordinate, 12 point and 12 tangent products.
   // x sits in the top slot of each packed point.
   // ---------------------------------------------------------------
   localparam int PW = cbspl_pkg::PROD_WIDTH;
   logic signed [C-1:0]  crd [NA][NP];
   logic signed [PW-1:0] s3_pp_in [NA][NP];
   logic signed [PW-1:0] s3_tp_in [NA][NP];
   logic signed [PW-1:0] s3_pp_ff [NA][NP];
   logic signed [PW-1:0] s3_tp_ff [NA][NP];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         for (int k = 0; k < NP; k++) begin
            crd[a][k]      = s2_pt_ff[k][(NA - 1 - a) * C +: C];
            s3_pp_in[a][k] = s2_w_ff[k] * crd[a][k];
            s3_tp_in[a][k] = s2_d_ff[k] * crd[a][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_pp_ff <= s3_pp_in;
         s3_tp_ff <= s3_tp_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: sum, add half of 6*2^F, shift out 2^(F+1), bias positive
   // so that the remaining divide by 3 is unsigned.
   // ---------------------------------------------------------------
   localparam int SW = cbspl_pkg::SUM_WIDTH;
   localparam int MQ = cbspl_pkg::MQ_WIDTH;
   localparam int MU = cbspl_pkg::MU_WIDTH;
   logic signed [SW-1:0] sum [NR];
   logic signed [SW-1:0] sum_sh [NR];
   logic [MU-1:0]        s4_mu_in [NR];
   logic [MU-1:0]        s4_mu_ff [NR];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         sum[a]      = SW'(s3_pp_ff[a][0]) + SW'(s3_pp_ff[a][1]) + SW'(s3_pp_ff[a][2])
                     + SW'(s3_pp_ff[a][3]) + $signed(cbspl_pkg::ROUND_OFS);
         sum[NA + a] = SW'(s3_tp_ff[a][0]) + SW'(s3_tp_ff[a][1]) + SW'(s3_tp_ff[a][2])
                     + SW'(s3_tp_ff[a][3]) + $signed(cbspl_pkg::ROUND_OFS);
      end
      for (int r = 0; r < NR; r++) begin
         sum_sh[r]   = sum[r] >>> (F + 1);
         s4_mu_in[r] = {sum_sh[r][MQ-1], sum_sh[r][MQ-1:0]} + cbspl_pkg::MU_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) s4_mu_ff <= s4_mu_in;
   end

   // ---------------------------------------------------------------
   // Stage 5: reciprocal multiply for the divide by 3.
   // ---------------------------------------------------------------
   logic [cbspl_pkg::DPROD_WIDTH-1:0] s5_dp_in [NR];
   logic [cbspl_pkg::DPROD_WIDTH-1:0] s5_dp_ff [NR];

   always_comb begin
      for (int r = 0; r < NR; r++) begin
         s5_dp_in[r] = s4_mu_ff[r] * cbspl_pkg::DIV_RECIP;
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) s5_dp_ff <= s5_dp_in;
   end

   // ---------------------------------------------------------------
   // Stage 6: take the quotient, remove the bias, saturate, register out.
   // ---------------------------------------------------------------
   localparam int QW = cbspl_pkg::QUO_WIDTH;
   logic signed [QW-1:0] quo [NR];
   logic signed [C-1:0]  pos_in [NA];
   logic signed [cbspl_pkg::TAN_WIDTH-1:0] tan_in [NA];
   logic signed [C-1:0]  pos_ff [NA];
   logic signed [cbspl_pkg::TAN_WIDTH-1:0] tan_ff [NA];

   always_comb begin
      for (int r = 0; r < NR; r++) begin
         quo[r] = $signed(s5_dp_ff[r][cbspl_pkg::DIV_SHIFT +: QW] - cbspl_pkg::Q_BIAS);
      end
      for (int a = 0; a < NA; a++) begin
         pos_in[a] = cbspl_pkg::sat_pos(quo[a]);
         tan_in[a] = cbspl_pkg::sat_tan(quo[NA + a]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         pos_ff <= pos_in;
         tan_ff <= tan_in;
      end
   end

   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];
   assign rsp_tan_x = tan_ff[0];
   assign rsp_tan_y = tan_ff[1];
   assign rsp_tan_z = tan_ff[2];

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // input is held off only when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("request stalled with an empty stage");

   // an accepted request lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request lost at stage 0");

   // a held stage keeps its request
   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !en[3]) |=> valid_ff[3])
      else $error("request dropped in a held stage");

   // clamped parameter never exceeds 1.0
   a_t_clamped: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (s0_t_ff <= cbspl_pkg::ONE))
      else $error("parameter not clamped");

endmodule

FILE: test/bspline_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for cubic_bspline_point_and_tangent_core: predicts point and tangent
// for every accepted request and checks the results in order. Depends on cbspl_pkg.
module bspline_result_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [cbspl_pkg::POINT_WIDTH-1:0] req_point_a,
   input  logic [cbspl_pkg::POINT_WIDTH-1:0] req_point_b,
   input  logic [cbspl_pkg::POINT_WIDTH-1:0] req_point_c,
   input  logic [cbspl_pkg::POINT_WIDTH-1:0] req_point_d,
   input  logic [cbspl_pkg::T_WIDTH-1:0] req_param_t,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic signed [cbspl_pkg::COORD_WIDTH-1:0] rsp_pos_x,
   input  logic signed [cbspl_pkg::COORD_WIDTH-1:0] rsp_pos_y,
   input  logic signed [cbspl_pkg::COORD_WIDTH-1:0] rsp_pos_z,
   input  logic signed [cbspl_pkg::TAN_WIDTH-1:0] rsp_tan_x,
   input  logic signed [cbspl_pkg::TAN_WIDTH-1:0] rsp_tan_y,
   input  logic signed [cbspl_pkg::TAN_WIDTH-1:0] rsp_tan_z,
   output int mismatch_count,
   output int pending_count
);

   localparam int COORD_WIDTH = cbspl_pkg::COORD_WIDTH;
   localparam int TAN_WIDTH   = cbspl_pkg::TAN_WIDTH;
   localparam int POINT_WIDTH = cbspl_pkg::POINT_WIDTH;
   localparam int T_WIDTH     = cbspl_pkg::T_WIDTH;
   localparam int T_FRAC_BITS = cbspl_pkg::T_FRAC_BITS;
   localparam int N_AXES      = cbspl_pkg::N_AXES;
   localparam int N_PTS       = cbspl_pkg::N_PTS;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] pos [N_AXES];
      logic signed [TAN_WIDTH-1:0]   tan [N_AXES];
   } curve_sample_type;

   localparam longint UNIT_T  = longint'(1) << T_FRAC_BITS;
   localparam longint DIVISOR = 6 * UNIT_T;

   string axis_tag [N_AXES] = '{"x", "y", "z"};
   curve_sample_type expected_samples [$];

   // num / (6 * one), nearest, ties toward +inf
   function automatic longint div_round(input longint num);
      longint n2, d2, q;
      n2 = 2 * num + DIVISOR;
      d2 = 2 * DIVISOR;
      q  = n2 / d2;
      if (n2 % d2 < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp_signed(input longint v, input int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -(longint'(1) << (bits - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic curve_sample_type eval_segment(
      input logic [POINT_WIDTH-1:0] pa, pb, pc, pd,
      input logic [T_WIDTH-1:0] t_raw);
      logic [POINT_WIDTH-1:0] ctrl [N_PTS];
      longint w [N_PTS];
      longint dw [N_PTS];
      longint t, t2, t3, pnum, tnum, c;
      int slot;
      curve_sample_type s;
      ctrl[0] = pa;
      ctrl[1] = pb;
      ctrl[2] = pc;
      ctrl[3] = pd;
      t = longint'(t_raw);
      if (t > UNIT_T) t = UNIT_T;   // t above one clamps
      t2 = (t * t + (UNIT_T >> 1)) >> T_FRAC_BITS;
      t3 = (t2 * t + (UNIT_T >> 1)) >> T_FRAC_BITS;
      w[0]  = -t3 + 3 * t2 - 3 * t + UNIT_T;
      w[1]  = 3 * t3 - 6 * t2 + 4 * UNIT_T;
      w[2]  = -3 * t3 + 3 * t2 + 3 * t + UNIT_T;
      w[3]  = t3;
      dw[0] = -3 * t2 + 6 * t - 3 * UNIT_T;
      dw[1] = 9 * t2 - 12 * t;
      dw[2] = -9 * t2 + 6 * t + 3 * UNIT_T;
      dw[3] = 3 * t2;
      for (int axis = 0; axis < N_AXES; axis++) begin
         slot = N_AXES - 1 - axis;   // x sits in the top slot
         pnum = 0;
         tnum = 0;
         for (int k = 0; k < N_PTS; k++) begin
            c = longint'($signed(ctrl[k][slot*COORD_WIDTH +: COORD_WIDTH]));
            pnum += w[k] * c;
            tnum += dw[k] * c;
         end
         s.pos[axis] = COORD_WIDTH'(clamp_signed(div_round(pnum), COORD_WIDTH));
         s.tan[axis] = TAN_WIDTH'(clamp_signed(div_round(tnum), TAN_WIDTH));
      end
      return s;
   endfunction

   always @(posedge clock) begin : score_step
      curve_sample_type got, want;
      int errs;
      errs = mismatch_count;
      if (reset) begin
         expected_samples.delete();
      end else begin
         // results first: a request never turns around in the same cycle
         if (rsp_valid && !rsp_stall) begin
            got.pos[0] = rsp_pos_x;
            got.pos[1] = rsp_pos_y;
            got.pos[2] = rsp_pos_z;
            got.tan[0] = rsp_tan_x;
            got.tan[1] = rsp_tan_y;
            got.tan[2] = rsp_tan_z;
            if (expected_samples.size() == 0) begin
               $error("result arrived with no request outstanding");
               errs++;
            end else begin
               want = expected_samples.pop_front();
               for (int a = 0; a < N_AXES; a++) begin
                  if (got.pos[a] !== want.pos[a]) begin
                     $error("pos_%s mismatch: expected %0d, got %0d",
                            axis_tag[a], want.pos[a], got.pos[a]);
                     errs++;
                  end
                  if (got.tan[a] !== want.tan[a]) begin
                     $error("tan_%s mismatch: expected %0d, got %0d",
                            axis_tag[a], want.tan[a], got.tan[a]);
                     errs++;
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            expected_samples.insert(expected_samples.size(),
               eval_segment(req_point_a, req_point_b, req_point_c, req_point_d,
                            req_param_t));
      end
      mismatch_count <= errs;
      pending_count  <= expected_samples.size();
   end

endmodule

FILE: test/tb_cubic_bspline_point_and_tangent_core.sv
`timescale 1ns / 100ps
// Top of the cubic B-spline evaluator testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on cbspl_pkg and bspline_result_checker.
module tb_cubic_bspline_point_and_tangent_core;

   localparam int COORD_WIDTH = cbspl_pkg::COORD_WIDTH;
   localparam int TAN_WIDTH   = cbspl_pkg::TAN_WIDTH;
   localparam int POINT_WIDTH = cbspl_pkg::POINT_WIDTH;
   localparam int T_WIDTH     = cbspl_pkg::T_WIDTH;
   localparam int T_FRAC_BITS = cbspl_pkg::T_FRAC_BITS;
   localparam int N_AXES      = cbspl_pkg::N_AXES;
   localparam logic [T_WIDTH-1:0] ONE = cbspl_pkg::ONE;

   // directed part first, then this many random requests
   localparam int RANDOM_REQUESTS = 1330;
   // cycles with no handshake on either channel before the run is declared hung
   localparam int IDLE_LIMIT   = 5000;
   // settle time after the last result
   localparam int DRAIN_CYCLES = 20;

   localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic [COORD_WIDTH-1:0] COORD_ZERO = '0;

   // corner control points: every axis at one extreme, or mixed per axis
   localparam logic [POINT_WIDTH-1:0] PT_MAX  = {N_AXES{COORD_MAX}};
   localparam logic [POINT_WIDTH-1:0] PT_MIN  = {N_AXES{COORD_MIN}};
   localparam logic [POINT_WIDTH-1:0] PT_ZERO = '0;
   localparam logic [POINT_WIDTH-1:0] PT_MIX  = {COORD_MAX, COORD_MIN, COORD_ZERO};
   localparam logic [POINT_WIDTH-1:0] PT_XIM  = {COORD_MIN, COORD_ZERO, COORD_MAX};

   // t corners: zero, one LSB, one half, just under one, one, and above one
   localparam int T_SWEEP [7] = '{0, 1, 1 << (T_FRAC_BITS - 1), (1 << T_FRAC_BITS) - 1,
                                  1 << T_FRAC_BITS, (1 << T_FRAC_BITS) + 1,
                                  (1 << T_WIDTH) - 1};
   localparam int T_THIRD = (1 << T_FRAC_BITS) / 3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [POINT_WIDTH-1:0] req_point_a;
   logic [POINT_WIDTH-1:0] req_point_b;
   logic [POINT_WIDTH-1:0] req_point_c;
   logic [POINT_WIDTH-1:0] req_point_d;
   logic [T_WIDTH-1:0] req_param_t;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [COORD_WIDTH-1:0] rsp_pos_x;
   logic signed [COORD_WIDTH-1:0] rsp_pos_y;
   logic signed [COORD_WIDTH-1:0] rsp_pos_z;
   logic signed [TAN_WIDTH-1:0] rsp_tan_x;
   logic signed [TAN_WIDTH-1:0] rsp_tan_y;
   logic signed [TAN_WIDTH-1:0] rsp_tan_z;

   int mismatch_count;
   int results_outstanding;
   int idle_cycles;
   bit burst_mode;   // while set the sender never idles

   cubic_bspline_point_and_tangent_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_a(req_point_a), .req_point_b(req_point_b),
      .req_point_c(req_point_c), .req_point_d(req_point_d),
      .req_param_t(req_param_t),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_tan_x(rsp_tan_x), .rsp_tan_y(rsp_tan_y), .rsp_tan_z(rsp_tan_z)
   );

   // Scoreboard sits beside the block and only watches the two channels.
   bspline_result_checker result_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_a(req_point_a), .req_point_b(req_point_b),
      .req_point_c(req_point_c), .req_point_d(req_point_d),
      .req_param_t(req_param_t),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_tan_x(rsp_tan_x), .rsp_tan_y(rsp_tan_y), .rsp_tan_z(rsp_tan_z),
      .mismatch_count(mismatch_count),
      .pending_count(results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // One coordinate: the rails, values just inside them, small values, or raw bits.
   function automatic logic [COORD_WIDTH-1:0] random_coord();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return COORD_MAX - COORD_WIDTH'($urandom_range(0, 3));
         3: return COORD_MIN + COORD_WIDTH'($urandom_range(0, 3));
         4, 5: return COORD_WIDTH'($urandom_range(0, 1023) - 512);
         default: return COORD_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [POINT_WIDTH-1:0] random_point();
      return {random_coord(), random_coord(), random_coord()};
   endfunction

   // t mostly in [0, 1]; the ends and the clamped range above one get extra weight.
   function automatic logic [T_WIDTH-1:0] random_param();
      int roll;
      roll = $urandom_range(0, 19);
      case (roll)
         0: return '0;
         1: return ONE;
         2, 3: return T_WIDTH'($urandom_range((1 << T_FRAC_BITS) + 1, (1 << T_WIDTH) - 1));
         default: return T_WIDTH'($urandom_range(0, 1 << T_FRAC_BITS));
      endcase
   endfunction

   // Present one request and hold it until accepted. valid is dropped only when
   // a gap is taken, so it never falls and rises within one time step.
   task automatic send_request(input logic [POINT_WIDTH-1:0] pa, pb, pc, pd,
                               input logic [T_WIDTH-1:0] tp);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_point_a <= pa;
      req_point_b <= pb;
      req_point_c <= pc;
      req_point_d <= pd;
      req_param_t <= tp;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Result back-pressure: runs of acceptance, some of them long, between stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 12))
            @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (pick_gap() + 1) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: any handshake on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_point_a = '0;
      req_point_b = '0;
      req_point_c = '0;
      req_point_d = '0;
      req_param_t = '0;
      burst_mode  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: alternating rails give the steepest tangents; sweep t through
      // its corners, including values past one that must clamp.
      for (int i = 0; i < 7; i++)
         send_request(PT_MAX, PT_MIN, PT_MAX, PT_MIN, T_WIDTH'(T_SWEEP[i]));
      for (int i = 0; i < 3; i++)
         send_request(PT_MIN, PT_MAX, PT_MIN, PT_MAX, T_WIDTH'(T_SWEEP[2 * i + 1]));
      // all points on one rail: the point lands on the rail, tangent is zero
      send_request(PT_MAX, PT_MAX, PT_MAX, PT_MAX, '0);
      send_request(PT_MAX, PT_MAX, PT_MAX, PT_MAX, T_WIDTH'(T_THIRD));
      send_request(PT_MAX, PT_MAX, PT_MAX, PT_MAX, ONE);
      send_request(PT_MIN, PT_MIN, PT_MIN, PT_MIN, '0);
      send_request(PT_MIN, PT_MIN, PT_MIN, PT_MIN, T_WIDTH'(T_THIRD));
      send_request(PT_MIN, PT_MIN, PT_MIN, PT_MIN, ONE);
      send_request(PT_ZERO, PT_ZERO, PT_ZERO, PT_ZERO, T_WIDTH'(T_SWEEP[6]));
      // each axis on a different value: max, min or zero
      send_request(PT_MIX, PT_XIM, PT_MIX, PT_XIM, '0);
      send_request(PT_XIM, PT_MIX, PT_XIM, PT_MIX, T_WIDTH'(T_THIRD * 2));
      send_request(PT_MIX, PT_XIM, PT_XIM, PT_MIX, ONE);

      // Random: no state in the block, so independent requests reach everything.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 150 == 0)
            burst_mode = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_REQUESTS / 2) begin
            // hold off until the pipeline has emptied completely
            req_valid <= 1'b0;
            do @(posedge clock); while (results_outstanding != 0);
         end
         send_request(random_point(), random_point(), random_point(), random_point(),
                      random_param());
      end

      // Drain: the count is registered, so look only after the next edge.
      req_valid <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
